/* hw/rtl/fpie_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpie_pkg
// Shared types, constants and the binary64 round-and-pack function used by
// the multiply and reciprocal units of the integer power core.
// ----------------------------------------------------------------------------
package fpie_pkg;

  localparam logic [63:0]        FP_ONE         = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0]        FP_QUIET_BIT   = 64'h0008_0000_0000_0000;
  localparam logic [63:0]        FP_DEFAULT_NAN = 64'hFFF8_0000_0000_0000;
  localparam logic [10:0]        FP_EXP_ALL1    = 11'h7FF;
  localparam logic signed [12:0] EXP_BIAS       = 13'sd1023;
  localparam logic signed [12:0] EXP_SUB_MIN    = -13'sd1022;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture a new input transfer
    logic mul_go;     // start one multiply
    logic mul_sq;     // 1: square the power, 0: product times power
    logic mag_shift;  // move to the next exponent bit
    logic rcp_go;     // start the reciprocal of the product
    logic out_load;   // move the answer into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mag_zero;
    logic mag_lsb;
    logic mag_last;   // no set bit above the current one
    logic positive;
    logic mul_done;
    logic rcp_done;
  } sts_t;

  // Rounds to nearest even and packs a finite nonzero value.
  // The value is m[54:2] * 2^(be - 1023 - 52) with m[54] set, m[1] the guard
  // bit and m[0] the sticky bit. Handles overflow and gradual underflow.
  function automatic logic [63:0] fp_round(input logic s, input logic signed [13:0] be,
                                           input logic [54:0] m);
    logic signed [13:0] sh;
    logic [5:0]         shamt;
    logic [54:0]        mm;
    logic [54:0]        lost;
    logic [10:0]        field;
    logic               inc;
    logic [62:0]        pk;
    sh    = 14'sd1 - be;
    shamt = (sh > 14'sd55) ? 6'd55 : sh[5:0];
    if (be >= 14'sd2047) begin
      return {s, FP_EXP_ALL1, 52'd0};
    end
    if (be >= 14'sd1) begin
      field = be[10:0];
      mm    = m;
    end else begin
      field = 11'd0;
      lost  = m & ~({55{1'b1}} << shamt);
      mm    = m >> shamt;
      mm[0] = mm[0] | (|lost);
    end
    inc = mm[1] & (mm[0] | mm[2]);
    pk  = {field, mm[53:2]} + {62'd0, inc};
    return {s, pk};
  endfunction

endpackage

/* hw/rtl/fpie_fmul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpie_fmul
// Multi-cycle binary64 multiplier: special-value decode, subnormal
// normalization one bit per cycle, four 27x27 partial products, rounding.
// ----------------------------------------------------------------------------
module fpie_fmul import fpie_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic        done_o,
  output logic [63:0] y_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_NORM = 2'd1;
  localparam logic [1:0] S_MUL  = 2'd2;
  localparam logic [1:0] S_RND  = 2'd3;

  logic [1:0]         state_r, state_nxt;
  logic [52:0]        ma_r, ma_nxt, mb_r, mb_nxt;
  logic signed [12:0] ea_r, ea_nxt, eb_r, eb_nxt;
  logic               s_r, s_nxt;
  logic [105:0]       acc_r, acc_nxt;
  logic [1:0]         cnt_r, cnt_nxt;
  logic [63:0]        y_r, y_nxt;
  logic               done_r, done_nxt;

  logic               a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  logic [26:0]        op_x, op_y;
  logic [53:0]        pp;
  logic [105:0]       pp_sh;
  logic signed [13:0] be;
  logic [54:0]        rm;

  // Operand classification.
  assign a_nan  = (a_i[62:52] == FP_EXP_ALL1) && (a_i[51:0] != 52'd0);
  assign b_nan  = (b_i[62:52] == FP_EXP_ALL1) && (b_i[51:0] != 52'd0);
  assign a_inf  = (a_i[62:52] == FP_EXP_ALL1) && (a_i[51:0] == 52'd0);
  assign b_inf  = (b_i[62:52] == FP_EXP_ALL1) && (b_i[51:0] == 52'd0);
  assign a_zero = (a_i[62:0] == 63'd0);
  assign b_zero = (b_i[62:0] == 63'd0);

  // One partial product per cycle, placed by its weight.
  always_comb begin
    case (cnt_r)
      2'd0: begin
        op_x = ma_r[26:0];
        op_y = mb_r[26:0];
      end
      2'd1: begin
        op_x = ma_r[26:0];
        op_y = {1'b0, mb_r[52:27]};
      end
      2'd2: begin
        op_x = {1'b0, ma_r[52:27]};
        op_y = mb_r[26:0];
      end
      default: begin
        op_x = {1'b0, ma_r[52:27]};
        op_y = {1'b0, mb_r[52:27]};
      end
    endcase
  end

  assign pp = op_x * op_y;

  always_comb begin
    case (cnt_r)
      2'd0:    pp_sh = {52'd0, pp};
      2'd3:    pp_sh = {pp[51:0], 54'd0};
      default: pp_sh = {25'd0, pp, 27'd0};
    endcase
  end

  // Normalize the 106-bit product into rounding form.
  always_comb begin
    if (acc_r[105]) begin
      be = 14'(ea_r) + 14'(eb_r) + 14'sd1024;
      rm = {acc_r[105:53], acc_r[52], |acc_r[51:0]};
    end else begin
      be = 14'(ea_r) + 14'(eb_r) + 14'sd1023;
      rm = {acc_r[104:52], acc_r[51], |acc_r[50:0]};
    end
  end

  // Sequencing of one multiply.
  always_comb begin
    state_nxt = state_r;
    ma_nxt    = ma_r;
    mb_nxt    = mb_r;
    ea_nxt    = ea_r;
    eb_nxt    = eb_r;
    s_nxt     = s_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    y_nxt     = y_r;
    done_nxt  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          s_nxt   = a_i[63] ^ b_i[63];
          ma_nxt  = {|a_i[62:52], a_i[51:0]};
          mb_nxt  = {|b_i[62:52], b_i[51:0]};
          ea_nxt  = (a_i[62:52] == 11'd0) ? EXP_SUB_MIN
                                          : $signed({2'b00, a_i[62:52]}) - EXP_BIAS;
          eb_nxt  = (b_i[62:52] == 11'd0) ? EXP_SUB_MIN
                                          : $signed({2'b00, b_i[62:52]}) - EXP_BIAS;
          acc_nxt = 106'd0;
          cnt_nxt = 2'd0;
          if (a_nan) begin
            y_nxt    = a_i | FP_QUIET_BIT;
            done_nxt = 1'b1;
          end else if (b_nan) begin
            y_nxt    = b_i | FP_QUIET_BIT;
            done_nxt = 1'b1;
          end else if ((a_inf && b_zero) || (a_zero && b_inf)) begin
            y_nxt    = FP_DEFAULT_NAN;
            done_nxt = 1'b1;
          end else if (a_inf || b_inf) begin
            y_nxt    = {a_i[63] ^ b_i[63], FP_EXP_ALL1, 52'd0};
            done_nxt = 1'b1;
          end else if (a_zero || b_zero) begin
            y_nxt    = {a_i[63] ^ b_i[63], 63'd0};
            done_nxt = 1'b1;
          end else begin
            state_nxt = S_NORM;
          end
        end
      end
      S_NORM: begin
        if (!ma_r[52]) begin
          ma_nxt = {ma_r[51:0], 1'b0};
          ea_nxt = ea_r - 13'sd1;
        end
        if (!mb_r[52]) begin
          mb_nxt = {mb_r[51:0], 1'b0};
          eb_nxt = eb_r - 13'sd1;
        end
        if (ma_r[52] && mb_r[52]) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        acc_nxt = acc_r + pp_sh;
        cnt_nxt = cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          state_nxt = S_RND;
        end
      end
      S_RND: begin
        y_nxt     = fp_round(s_r, be, rm);
        done_nxt  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    ma_r  <= ma_nxt;
    mb_r  <= mb_nxt;
    ea_r  <= ea_nxt;
    eb_r  <= eb_nxt;
    s_r   <= s_nxt;
    acc_r <= acc_nxt;
    cnt_r <= cnt_nxt;
    y_r   <= y_nxt;
  end

  assign done_o = done_r;
  assign y_o    = y_r;

endmodule

/* hw/rtl/fpie_frcp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpie_frcp
// Multi-cycle binary64 reciprocal 1.0 / p: special-value decode, subnormal
// normalization, restoring division one quotient bit per cycle, rounding.
// ----------------------------------------------------------------------------
module fpie_frcp import fpie_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] p_i,
  output logic        done_o,
  output logic [63:0] y_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_NORM = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_RND  = 2'd3;
  localparam logic [5:0] QBITS  = 6'd55;

  logic [1:0]         state_r, state_nxt;
  logic [52:0]        mp_r, mp_nxt;
  logic signed [12:0] ep_r, ep_nxt;
  logic               s_r, s_nxt;
  logic [53:0]        rem_r, rem_nxt;
  logic [55:0]        q_r, q_nxt;
  logic [5:0]         cnt_r, cnt_nxt;
  logic [63:0]        y_r, y_nxt;
  logic               done_r, done_nxt;

  logic               qbit;
  logic [53:0]        rem_sub;
  logic signed [13:0] be;
  logic [54:0]        rm;

  // One restoring division step.
  assign qbit    = rem_r >= {1'b0, mp_r};
  assign rem_sub = qbit ? (rem_r - {1'b0, mp_r}) : rem_r;

  // Place the quotient's leading one for rounding.
  always_comb begin
    if (q_r[55]) begin
      be = 14'sd1023 - 14'(ep_r);
      rm = {q_r[55:3], q_r[2], |q_r[1:0] | (rem_r != 54'd0)};
    end else begin
      be = 14'sd1022 - 14'(ep_r);
      rm = {q_r[54:2], q_r[1], q_r[0] | (rem_r != 54'd0)};
    end
  end

  always_comb begin
    state_nxt = state_r;
    mp_nxt    = mp_r;
    ep_nxt    = ep_r;
    s_nxt     = s_r;
    rem_nxt   = rem_r;
    q_nxt     = q_r;
    cnt_nxt   = cnt_r;
    y_nxt     = y_r;
    done_nxt  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          s_nxt   = p_i[63];
          mp_nxt  = {|p_i[62:52], p_i[51:0]};
          ep_nxt  = (p_i[62:52] == 11'd0) ? EXP_SUB_MIN
                                          : $signed({2'b00, p_i[62:52]}) - EXP_BIAS;
          rem_nxt = {2'b01, 52'd0};
          q_nxt   = 56'd0;
          cnt_nxt = 6'd0;
          if ((p_i[62:52] == FP_EXP_ALL1) && (p_i[51:0] != 52'd0)) begin
            y_nxt    = p_i | FP_QUIET_BIT;
            done_nxt = 1'b1;
          end else if (p_i[62:0] == 63'd0) begin
            y_nxt    = {p_i[63], FP_EXP_ALL1, 52'd0};
            done_nxt = 1'b1;
          end else if (p_i[62:52] == FP_EXP_ALL1) begin
            y_nxt    = {p_i[63], 63'd0};
            done_nxt = 1'b1;
          end else begin
            state_nxt = S_NORM;
          end
        end
      end
      S_NORM: begin
        if (!mp_r[52]) begin
          mp_nxt = {mp_r[51:0], 1'b0};
          ep_nxt = ep_r - 13'sd1;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        q_nxt   = {q_r[54:0], qbit};
        rem_nxt = {rem_sub[52:0], 1'b0};
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == QBITS) begin
          state_nxt = S_RND;
        end
      end
      S_RND: begin
        y_nxt     = fp_round(s_r, be, rm);
        done_nxt  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    mp_r  <= mp_nxt;
    ep_r  <= ep_nxt;
    s_r   <= s_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    cnt_r <= cnt_nxt;
    y_r   <= y_nxt;
  end

  assign done_o = done_r;
  assign y_o    = y_r;

endmodule

/* hw/rtl/fpie_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpie_datapath
// Holds the running product, the running power and the exponent magnitude,
// and owns the shared multiplier, the reciprocal unit and the output register.
// ----------------------------------------------------------------------------
module fpie_datapath import fpie_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic [63:0] base,
  input  logic [31:0] exponent,
  output logic [63:0] power
);

  logic [63:0] prod_r, prod_nxt;
  logic [63:0] sq_r, sq_nxt;
  logic [32:0] mag_r, mag_nxt;
  logic        pos_r, pos_nxt;
  logic        sel_r, sel_nxt;
  logic [63:0] out_r, out_nxt;

  logic        mul_done, rcp_done;
  logic [63:0] mul_y, rcp_y;
  logic [63:0] mul_a;

  // Product times power, or power squared.
  assign mul_a = cmd.mul_sq ? sq_r : prod_r;

  fpie_fmul u_fmul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.mul_go),
    .a_i    (mul_a),
    .b_i    (sq_r),
    .done_o (mul_done),
    .y_o    (mul_y)
  );

  fpie_frcp u_frcp (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.rcp_go),
    .p_i    (prod_r),
    .done_o (rcp_done),
    .y_o    (rcp_y)
  );

  // Register updates.
  always_comb begin
    prod_nxt = prod_r;
    sq_nxt   = sq_r;
    mag_nxt  = mag_r;
    pos_nxt  = pos_r;
    sel_nxt  = sel_r;
    out_nxt  = out_r;
    if (cmd.load) begin
      prod_nxt = FP_ONE;
      sq_nxt   = base;
      mag_nxt  = exponent[31] ? (33'h1_0000_0000 - {1'b0, exponent}) : {1'b0, exponent};
      pos_nxt  = !exponent[31] && (exponent != 32'd0);
    end
    if (cmd.mul_go) begin
      sel_nxt = cmd.mul_sq;
    end
    if (mul_done) begin
      if (sel_r) begin
        sq_nxt = mul_y;
      end else begin
        prod_nxt = mul_y;
      end
    end
    if (cmd.mag_shift) begin
      mag_nxt = {1'b0, mag_r[32:1]};
    end
    if (cmd.out_load) begin
      out_nxt = pos_r ? prod_r : rcp_y;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    sq_r   <= sq_nxt;
    mag_r  <= mag_nxt;
    pos_r  <= pos_nxt;
    sel_r  <= sel_nxt;
    out_r  <= out_nxt;
  end

  assign sts.mag_zero = (mag_r == 33'd0);
  assign sts.mag_lsb  = mag_r[0];
  assign sts.mag_last = (mag_r[32:1] == 32'd0);
  assign sts.positive = pos_r;
  assign sts.mul_done = mul_done;
  assign sts.rcp_done = rcp_done;
  assign power        = out_r;

endmodule

/* hw/rtl/fpie_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpie_ctrl
// Controller: walks the exponent bits, issues multiplies and the final
// reciprocal, and runs the input and output handshakes.
// ----------------------------------------------------------------------------
module fpie_ctrl import fpie_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  output logic out_tvalid,
  input  logic out_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_STEP   = 3'd1;
  localparam logic [2:0] ST_MULP   = 3'd2;
  localparam logic [2:0] ST_MULS   = 3'd3;
  localparam logic [2:0] ST_RCP    = 3'd4;
  localparam logic [2:0] ST_RESULT = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       ovalid_r, ovalid_nxt;
  logic       out_free;

  assign out_free  = !ovalid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_STEP;
        end
      end
      // Decide the work for the current exponent bit.
      ST_STEP: begin
        if (sts.mag_zero) begin
          if (sts.positive) begin
            state_nxt = ST_RESULT;
          end else begin
            cmd.rcp_go = 1'b1;
            state_nxt  = ST_RCP;
          end
        end else if (sts.mag_lsb) begin
          cmd.mul_go = 1'b1;
          state_nxt  = ST_MULP;
        end else begin
          cmd.mul_go = 1'b1;
          cmd.mul_sq = 1'b1;
          state_nxt  = ST_MULS;
        end
      end
      // The squaring after the last set bit is skipped.
      ST_MULP: begin
        if (sts.mul_done) begin
          if (sts.mag_last) begin
            cmd.mag_shift = 1'b1;
            state_nxt     = ST_STEP;
          end else begin
            cmd.mul_go = 1'b1;
            cmd.mul_sq = 1'b1;
            state_nxt  = ST_MULS;
          end
        end
      end
      ST_MULS: begin
        if (sts.mul_done) begin
          cmd.mag_shift = 1'b1;
          state_nxt     = ST_STEP;
        end
      end
      ST_RCP: begin
        if (sts.rcp_done) begin
          state_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output valid flag.
  always_comb begin
    ovalid_nxt = ovalid_r;
    if (out_tready) begin
      ovalid_nxt = 1'b0;
    end
    if (cmd.out_load) begin
      ovalid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  assign out_tvalid = ovalid_r;

endmodule

/* hw/rtl/float_power_integer_exponent_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// float_power_integer_exponent_core
// Binary64 base raised to a signed 32-bit integer exponent by
// square-and-multiply, with a final reciprocal for non-positive exponents.
// ----------------------------------------------------------------------------
// Usage: present base and exponent on the input stream; one transfer yields
// one result transfer carrying the binary64 power.
// Each multiply runs through the shared multiplier, and a subnormal operand
// first adds a normalization step per leading zero. One multiply runs
// per set exponent bit and one squaring per bit below the top set bit, so a
// 33-bit magnitude of at most 2^31 needs up to 61 multiplies. Each bit also
// passes through a decision state. A zero or negative exponent adds the
// bit-serial reciprocal.
// Throughput: one item at a time; in_tready is high only while idle.
// The output register holds a finished result while the receiver stalls,
// and the next item may be accepted meanwhile; it is written back only once
// the previous result has been transferred.
// Reset clears the controller and the output valid flag.
// ----------------------------------------------------------------------------
module float_power_integer_exponent_core import fpie_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // [63:0] base, [95:64] exponent
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata   // [63:0] power
);

  cmd_t cmd;
  sts_t sts;

  fpie_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  fpie_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .base     (in_tdata[63:0]),
    .exponent (in_tdata[95:64]),
    .power    (out_tdata)
  );

  // The block is busy right after accepting an item.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while busy");

  // The result register is never overwritten while a result waits.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_tvalid || out_tready))
    else $error("output overwritten before transfer");

  // Only one arithmetic unit finishes at a time.
  a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
    !(sts.mul_done && sts.rcp_done))
    else $error("multiply and reciprocal finished together");

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the binary64 integer power core. Base and exponent
// pairs stream in through directed corner cases and then random phases with
// varying sender gaps and receiver stalls. Each accepted transfer is
// predicted by square-and-multiply in real arithmetic and every result
// transfer is compared in order against the predicted bit pattern.
// ----------------------------------------------------------------------------
module tb;
  import fpie_pkg::*;

  // Scoreboard holding the predicted powers in transfer order.
  class power_scoreboard;
    logic [63:0] power_q[$];
    int          errors;

    // Square-and-multiply over the exponent magnitude, LSB first.
    function automatic logic [63:0] predict_power(input logic [63:0] base,
                                                  input logic [31:0] expo);
      logic [32:0] mag;
      real         prod;
      real         sq;
      logic [63:0] pb;
      mag  = expo[31] ? (33'h1_0000_0000 - {1'b0, expo}) : {1'b0, expo};
      prod = $bitstoreal(FP_ONE);
      sq   = $bitstoreal(base);
      while (mag != 0) begin
        if (mag[0]) begin
          prod = prod * sq;
        end
        sq  = sq * sq;
        mag = mag >> 1;
      end
      pb = $realtobits(prod);
      if (!expo[31] && expo != 0) begin
        return pb;
      end
      // Reciprocal of a signed zero is the infinity of the same sign.
      if (pb[62:0] == 63'd0) begin
        return {pb[63], FP_EXP_ALL1, 52'd0};
      end
      return $realtobits($bitstoreal(FP_ONE) / prod);
    endfunction

    function void note_input(input logic [63:0] base, input logic [31:0] expo);
      power_q.push_back(predict_power(base, expo));
    endfunction

    task report(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_power(input logic [63:0] got);
      logic [63:0] want;
      if (power_q.size() == 0) begin
        report($sformatf("unexpected result %h", got));
        return;
      end
      want = power_q.pop_front();
      if (got !== want) begin
        report($sformatf("power %h, expected %h", got, want));
      end
    endtask

    function int pending();
      return power_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;

  power_scoreboard sb = new();
  int in_idle_pct;
  int out_stall_pct;
  int hold_cycles;

  float_power_integer_exponent_core dut (.*);

  always #5 clk = ~clk;

  // Timeout.
  initial begin
    #200ms;
    $display("TEST FAILED");
    $finish;
  end

  // Receiver: random stalls, an optional long hold-off, and result checks.
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        sb.check_power(out_tdata);
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= out_stall_pct);
      end
    end
  end

  // Offers one transfer, after a random gap, and waits for acceptance.
  task automatic send_item(input logic [63:0] base, input logic [31:0] expo);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {expo, base};
    do @(posedge clk); while (!in_tready);
    sb.note_input(base, expo);
  endtask

  task automatic wait_drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Random base: mostly values near one so long exponents stay finite.
  function automatic logic [63:0] rand_base();
    logic [63:0] b;
    int          kind;
    b    = {$urandom, $urandom};
    kind = $urandom_range(9);
    if (kind < 4) begin
      b[62:52] = 11'h3FE + 11'($urandom_range(1));
    end else if (kind < 6) begin
      b[62:52] = 11'h3F0 + 11'($urandom_range(31));
    end else if (kind == 6) begin
      b[62:52] = 11'd0;
    end else if (kind == 7) begin
      b[62:52] = FP_EXP_ALL1 - 11'($urandom_range(1));
    end
    return b;
  endfunction

  function automatic logic [31:0] rand_expo();
    int kind;
    kind = $urandom_range(9);
    if (kind < 6) begin
      return $urandom_range(80) - 40;
    end else if (kind < 8) begin
      return $urandom_range(4000) - 2000;
    end
    return $urandom;
  endfunction

  task automatic random_phase(input int n, input int idle, input int stall);
    in_idle_pct   = idle;
    out_stall_pct = stall;
    repeat (n) send_item(rand_base(), rand_expo());
  endtask

  initial begin
    logic [63:0] bases[14];
    logic [31:0] expos[6];
    in_idle_pct   = 0;
    out_stall_pct = 0;
    hold_cycles   = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: special bases against special exponents.
    bases = '{64'h0, 64'h8000_0000_0000_0000, 64'h7FF0_0000_0000_0000,
              64'hFFF0_0000_0000_0000, 64'h7FF8_0000_0000_0001, FP_ONE,
              64'hBFF0_0000_0000_0000, 64'h4000_0000_0000_0000,
              64'h3FE0_0000_0000_0000, 64'h7FEF_FFFF_FFFF_FFFF,
              64'h0000_0000_0000_0001, 64'h800F_FFFF_FFFF_FFFF,
              64'hC008_0000_0000_0000, 64'h3FF0_0000_0000_0001};
    expos = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'd3};
    foreach (bases[i]) send_item(bases[i], expos[i % 6]);
    send_item(64'h0, 32'hFFFF_FFFF);
    send_item(64'h8000_0000_0000_0000, 32'hFFFF_FFFD);
    send_item(64'h7FF8_0000_0000_0001, 32'h8000_0000);
    send_item(64'hBFF0_0000_0000_0000, 32'h8000_0000);
    send_item(64'h4000_0000_0000_0000, 32'd1100);
    send_item(64'h4000_0000_0000_0000, 32'hFFFF_FBC0);
    wait_drain();

    random_phase(400, 0, 0);
    random_phase(400, 55, 0);
    random_phase(400, 0, 55);

    // Long receiver hold-off while the sender keeps offering.
    in_idle_pct = 0;
    hold_cycles = 3000;
    repeat (20) send_item(rand_base(), rand_expo());
    wait_drain();

    random_phase(400, 9, 9);
    wait_drain();
    random_phase(30, 0, 0);

    wait_drain();
    repeat (200) @(posedge clk);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

/* sim.f */
hw/rtl/fpie_pkg.sv
hw/rtl/fpie_fmul.sv
hw/rtl/fpie_frcp.sv
hw/rtl/fpie_datapath.sv
hw/rtl/fpie_ctrl.sv
hw/rtl/float_power_integer_exponent_core.sv
tb/tb.sv
